>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Types, character constants and helpers for the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int LENGTH_WIDTH_DEF   = 16;

  // step queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOF   = 8'h66;
  localparam logic [7:0] CH_LOZ   = 8'h7A;

  typedef enum logic [4:0] {
    TK_EOF, TK_NEWLINE, TK_INT, TK_FLOAT, TK_TRUE, TK_FALSE, TK_IDENT, TK_STRING,
    TK_BANG, TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK, TK_PLUS, TK_MINUS,
    TK_COMMA, TK_SEMI, TK_COLON, TK_ASSIGN, TK_LBRACE, TK_RBRACE, TK_PIPE,
    TK_LT, TK_LE, TK_GT, TK_GE, TK_COMMENT, TK_INVALID
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_UNTERMINATED, ERR_BAD_CHAR
  } err_t;

  typedef enum logic [3:0] {
    SC_IDLE, SC_NUMBER, SC_IDENT, SC_STRING, SC_COMMENT, SC_COMMENT_CR,
    SC_COMMENT_LF, SC_HOLD_CR, SC_HOLD_LF, SC_HOLD_LT, SC_HOLD_GT, SC_HOLD_MINUS
  } scan_state_t;

  // channel words
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic        run_end;
  } out_word_t;

  // one finished token
  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] start;
    logic [15:0] length;
    err_t        err;
  } tok_t;

  // all tokens caused by one input byte
  typedef struct packed {
    logic has_two;
    tok_t tok0;
    tok_t tok1;
  } step_rec_t;

  typedef struct packed {
    logic      valid;
    step_rec_t rec;
  } push_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[CH_LOA:CH_LOZ], [CH_UPA:CH_UPZ]};
  endfunction

  // single-character symbols; TK_EOF means not a symbol
  function automatic tok_kind_t symbol_kind(input logic [7:0] b);
    tok_kind_t k;
    case (b)
      "!":     k = TK_BANG;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "[":     k = TK_LBRACK;
      "]":     k = TK_RBRACK;
      "+":     k = TK_PLUS;
      ",":     k = TK_COMMA;
      ";":     k = TK_SEMI;
      ":":     k = TK_COLON;
      CH_EQ:   k = TK_ASSIGN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "|":     k = TK_PIPE;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming tokenizer for script text: one byte in, finished tokens out.
//
//   channel  | dir | word       | handshake
//   ---------+-----+------------+------------------------
//   byte     | in  | in_word_t  | byte_valid / byte_stall
//   token    | out | out_word_t | token_valid / token_stall
//
// One byte is taken every cycle while the step queue is not full; the scanner state updates in that cycle.
// Tokens leave one per cycle while token_stall is low; a byte that closes two
// tokens sends them in turn, and the four-record step queue absorbs such bursts.
// byte_stall is high only while the step queue is full.
// Reset is synchronous and leaves scanner and queue empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module script_token_lexer import stl_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int LENGTH_WIDTH   = LENGTH_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_word_t  byte_word,
  output logic      token_valid,
  input  logic      token_stall,
  output out_word_t token_word
);

  push_t     push;
  logic      pop;
  step_rec_t head;
  q_status_t q_status;

  stl_front #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LENGTH_WIDTH   (LENGTH_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_word  (byte_word),
    .q_status   (q_status),
    .byte_stall (byte_stall),
    .push       (push)
  );

  stl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  stl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .token_stall (token_stall),
    .token_valid (token_valid),
    .token_word  (token_word),
    .pop         (pop)
  );

  // checks
  `ASSERT_NEVER(a_push_when_full, push.valid && q_status.full, "record pushed into full queue")
  `ASSERT_CLK(a_second_follows, (token_valid && !token_stall && !token_word.run_end) |=> token_valid, "second token of a byte missing")
  `ASSERT_CLK(a_eof_len_zero, (token_valid && token_word.token_kind == TK_EOF) |-> (token_word.token_length == 16'd0), "eof token with nonzero length")
  `ASSERT_CLK(a_bad_char_err, (token_valid && token_word.token_kind == TK_INVALID) |-> (token_word.error_code == ERR_BAD_CHAR), "invalid token without error")

endmodule

>>> rtl/core/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front
// Scanner front end: takes one byte per cycle when the queue is not full,
// updates token state, hands the byte's tokens to the queue as one record.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int LENGTH_WIDTH   = LENGTH_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  in_word_t  byte_word,
  input  q_status_t q_status,
  output logic      byte_stall,
  output push_t     push
);

  typedef struct packed {
    logic      v;
    tok_kind_t kind;
    err_t      err;
  } flush_t;

  scan_state_t               scan_state;
  logic [POSITION_WIDTH-1:0] byte_position;
  logic [POSITION_WIDTH-1:0] start_position;
  logic [LENGTH_WIDTH-1:0]   run_length;
  logic                      saw_point;
  logic [7:0]                held_byte;

  scan_state_t               scan_state_next;
  logic [POSITION_WIDTH-1:0] byte_position_next;
  logic [POSITION_WIDTH-1:0] start_position_next;
  logic [LENGTH_WIDTH-1:0]   run_length_next;
  logic                      saw_point_next;
  logic [7:0]                held_byte_next;

  logic      accept;
  logic      a_v, b_v, c_v;
  tok_t      a_tok, b_tok, c_tok;
  step_rec_t rec;

  function automatic logic [LENGTH_WIDTH-1:0] len_inc(input logic [LENGTH_WIDTH-1:0] v);
    return (v == '1) ? v : v + LENGTH_WIDTH'(1);
  endfunction

  // token left pending by a state when it is cut off
  function automatic flush_t flush_tok(input scan_state_t st,
                                       input logic [LENGTH_WIDTH-1:0] len,
                                       input logic [7:0] held, input logic point);
    flush_t f;
    f = '{v: 1'b1, kind: TK_EOF, err: ERR_NONE};
    case (st)
      SC_NUMBER: begin
        if (point) f.kind = TK_FLOAT;
        else if (len == LENGTH_WIDTH'(1) && held == CH_1) f.kind = TK_TRUE;
        else if (len == LENGTH_WIDTH'(1) && held == CH_0) f.kind = TK_FALSE;
        else f.kind = TK_INT;
      end
      SC_IDENT:  f.kind = TK_IDENT;
      SC_STRING: begin
        f.kind = TK_STRING;
        f.err  = ERR_UNTERMINATED;
      end
      SC_COMMENT, SC_COMMENT_CR, SC_COMMENT_LF: f.kind = TK_COMMENT;
      SC_HOLD_CR, SC_HOLD_LF: f.kind = TK_NEWLINE;
      SC_HOLD_LT:    f.kind = TK_LT;
      SC_HOLD_GT:    f.kind = TK_GT;
      SC_HOLD_MINUS: f.kind = TK_MINUS;
      default:       f.v = 1'b0;
    endcase
    return f;
  endfunction

  assign byte_stall = q_status.full;
  assign accept     = byte_valid && !q_status.full;

  // scanner step: continue token, rescan from idle, flush on final byte
  always_comb begin
    logic [7:0]                b;
    logic [POSITION_WIDTH-1:0] pos;
    logic                      rescan;
    logic                      pair;
    flush_t                    f;
    tok_kind_t                 sk;

    b      = byte_word.data_byte;
    pos    = byte_position;
    rescan = 1'b0;
    pair   = 1'b0;
    f      = '0;
    sk     = symbol_kind(b);
    a_v    = 1'b0;
    b_v    = 1'b0;
    c_v    = 1'b0;
    a_tok  = '0;
    b_tok  = '0;
    c_tok  = '0;

    scan_state_next     = scan_state;
    start_position_next = start_position;
    run_length_next     = run_length;
    saw_point_next      = saw_point;
    held_byte_next      = held_byte;

    // continue the token in progress
    case (scan_state)
      SC_NUMBER: begin
        if (is_digit(b) || b == CH_POINT || b == CH_LOF) begin
          run_length_next = len_inc(run_length);
          if (b == CH_POINT) saw_point_next = 1'b1;
        end else begin
          rescan = 1'b1;
        end
      end
      SC_IDENT: begin
        if (run_length == LENGTH_WIDTH'(1) && held_byte == CH_LOF && is_digit(b)) begin
          scan_state_next = SC_NUMBER;
          run_length_next = LENGTH_WIDTH'(2);
          saw_point_next  = 1'b0;
        end else if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
          run_length_next = len_inc(run_length);
        end else begin
          rescan = 1'b1;
        end
      end
      SC_STRING: begin
        if (b == CH_QUOTE) begin
          a_v             = 1'b1;
          a_tok           = '{kind: TK_STRING, start: 32'(start_position),
                              length: 16'(len_inc(run_length)), err: ERR_NONE};
          scan_state_next = SC_IDLE;
        end else if (b == CH_NUL || b == CH_CR || b == CH_LF) begin
          rescan = 1'b1;
        end else begin
          run_length_next = len_inc(run_length);
        end
      end
      SC_COMMENT: begin
        if (b == CH_NUL) begin
          rescan = 1'b1;
        end else begin
          run_length_next = len_inc(run_length);
          if (b == CH_CR) scan_state_next = SC_COMMENT_CR;
          else if (b == CH_LF) scan_state_next = SC_COMMENT_LF;
        end
      end
      SC_COMMENT_CR, SC_COMMENT_LF, SC_HOLD_CR, SC_HOLD_LF: begin
        pair = (b == CH_LF && (scan_state == SC_COMMENT_CR || scan_state == SC_HOLD_CR))
            || (b == CH_CR && (scan_state == SC_COMMENT_LF || scan_state == SC_HOLD_LF));
        if (pair) begin
          f               = flush_tok(scan_state, run_length, held_byte, saw_point);
          a_v             = 1'b1;
          a_tok           = '{kind: f.kind, start: 32'(start_position),
                              length: 16'(len_inc(run_length)), err: f.err};
          run_length_next = len_inc(run_length);
          scan_state_next = SC_IDLE;
        end else begin
          rescan = 1'b1;
        end
      end
      SC_HOLD_LT, SC_HOLD_GT: begin
        if (b == CH_EQ) begin
          a_v             = 1'b1;
          a_tok           = '{kind: (scan_state == SC_HOLD_LT) ? TK_LE : TK_GE,
                              start: 32'(start_position), length: 16'd2, err: ERR_NONE};
          scan_state_next = SC_IDLE;
        end else begin
          rescan = 1'b1;
        end
      end
      SC_HOLD_MINUS: begin
        if (is_digit(b)) begin
          scan_state_next = SC_NUMBER;
          run_length_next = LENGTH_WIDTH'(2);
          saw_point_next  = 1'b0;
        end else begin
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    // cut off the pending token, then scan the byte from idle
    if (rescan) begin
      f = flush_tok(scan_state, run_length, held_byte, saw_point);
      if (scan_state != SC_IDLE) begin
        a_v   = f.v;
        a_tok = '{kind: f.kind, start: 32'(start_position),
                  length: 16'(run_length), err: f.err};
      end
      scan_state_next = SC_IDLE;
      if (b == CH_NUL) begin
        b_v   = 1'b1;
        b_tok = '{kind: TK_EOF, start: 32'(pos), length: 16'd0, err: ERR_NONE};
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) begin
        b_v = 1'b0;
      end else if (b == CH_CR || b == CH_LF || is_digit(b) || b == CH_POINT
                   || is_alpha(b) || b == CH_UNDER || b == CH_MINUS || b == CH_QUOTE
                   || b == CH_HASH || b == CH_LT || b == CH_GT) begin
        if (b == CH_CR) scan_state_next = SC_HOLD_CR;
        else if (b == CH_LF) scan_state_next = SC_HOLD_LF;
        else if (is_digit(b) || b == CH_POINT) scan_state_next = SC_NUMBER;
        else if (is_alpha(b) || b == CH_UNDER) scan_state_next = SC_IDENT;
        else if (b == CH_MINUS) scan_state_next = SC_HOLD_MINUS;
        else if (b == CH_QUOTE) scan_state_next = SC_STRING;
        else if (b == CH_HASH) scan_state_next = SC_COMMENT;
        else if (b == CH_LT) scan_state_next = SC_HOLD_LT;
        else scan_state_next = SC_HOLD_GT;
        start_position_next = pos;
        run_length_next     = LENGTH_WIDTH'(1);
        held_byte_next      = b;
        saw_point_next      = (b == CH_POINT);
      end else if (sk != TK_EOF) begin
        b_v   = 1'b1;
        b_tok = '{kind: sk, start: 32'(pos), length: 16'd1, err: ERR_NONE};
      end else begin
        b_v   = 1'b1;
        b_tok = '{kind: TK_INVALID, start: 32'(pos), length: 16'd1, err: ERR_BAD_CHAR};
      end
    end

    // final byte: flush whatever is left and restart the position
    if (byte_word.final_byte) begin
      f               = flush_tok(scan_state_next, run_length_next, held_byte_next,
                                  saw_point_next);
      c_v             = f.v;
      c_tok           = '{kind: f.kind, start: 32'(start_position_next),
                          length: 16'(run_length_next), err: f.err};
      scan_state_next = SC_IDLE;
      byte_position_next = '0;
    end else begin
      byte_position_next = pos + POSITION_WIDTH'(1);
    end

    // pack up to two tokens in order
    rec.has_two = (a_v && (b_v || c_v)) || (b_v && c_v);
    rec.tok0    = a_v ? a_tok : (b_v ? b_tok : c_tok);
    rec.tok1    = (a_v && b_v) ? b_tok : c_tok;
  end

  assign push.valid = accept && (a_v || b_v || c_v);
  assign push.rec   = rec;

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= SC_IDLE;
      byte_position  <= '0;
      start_position <= '0;
      run_length     <= '0;
      saw_point      <= 1'b0;
      held_byte      <= '0;
    end else if (accept) begin
      scan_state     <= scan_state_next;
      byte_position  <= byte_position_next;
      start_position <= start_position_next;
      run_length     <= run_length_next;
      saw_point      <= saw_point_next;
      held_byte      <= held_byte_next;
    end
  end

endmodule

>>> rtl/core/stl_fifo.sv
// ----------------------------------------------------------------------------
// stl_fifo
// Short queue of step records between scanner and output stage.
// ----------------------------------------------------------------------------
module stl_fifo import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  input  logic      pop,
  output step_rec_t head,
  output q_status_t q_status
);

  step_rec_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign do_push = push.valid && (count != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count != '0);

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push.rec;
  end

  // pointers and fill count; pointers wrap since depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  assign head           = entries[rd_ptr];
  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign q_status.count = count;

endmodule

>>> rtl/core/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back
// Output stage: sends the tokens of the head record one word at a time and
// marks the last one of each byte.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_rec_t head,
  input  q_status_t q_status,
  input  logic      token_stall,
  output logic      token_valid,
  output out_word_t token_word,
  output logic      pop
);

  logic second;   // sending the second token of the head record
  logic last;
  tok_t cur;

  assign cur         = second ? head.tok1 : head.tok0;
  assign last        = second || !head.has_two;
  assign token_valid = !q_status.empty;
  assign pop         = token_valid && !token_stall && last;

  assign token_word.token_kind   = cur.kind;
  assign token_word.token_start  = cur.start;
  assign token_word.token_length = cur.length;
  assign token_word.error_code   = cur.err;
  assign token_word.run_end      = last;

  // word select within the record
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (token_valid && !token_stall) begin
      second <= !last;
    end
  end

endmodule
